/* rtl/core/gbe_pkg.sv */
// Package for the gap buffer editor: opcode and status codes, the FSM
// state type and the memory control struct shared by the core modules.
// No dependencies.
package gbe_pkg;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_MOVE   = 3'd1,
        OP_ERASE  = 3'd2,
        OP_READ   = 3'd3,
        OP_CLEAR  = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COPY,
        S_DRAIN,
        S_READ,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    localparam int AMOUNT_W = 11;
    localparam int FIELD_W  = 10;

endpackage

/* rtl/core/gbe_text_ram.sv */
// Text store of the gap buffer editor: one write port and one read port
// with registered read data. Depends on gbe_pkg for the control struct.
module gbe_text_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  gbe_pkg::mem_ctl_t mem_ctl,
    input  logic [AW-1:0]     waddr,
    input  logic [7:0]        wdata,
    input  logic [AW-1:0]     raddr,
    output logic [7:0]        rdata
);
    import gbe_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_ctl.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/gbe_ctrl.sv */
// Sequencer of the gap buffer editor: gap pointers, operation decode,
// the copy loop that carries bytes across the gap, and the result register.
// Depends on gbe_pkg; drives the ports of gbe_text_ram.
module gbe_ctrl #(
    parameter int CAPACITY = 1024,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic [2:0]            opcode,
    input  logic [7:0]            insert_byte,
    input  logic signed [10:0]    amount,
    input  logic [9:0]            position,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [1:0]            status,
    output logic [7:0]            read_byte,
    output logic [9:0]            cursor,
    output logic [9:0]            text_length,
    output gbe_pkg::mem_ctl_t     mem_ctl,
    output logic [AW-1:0]         waddr,
    output logic [7:0]            wdata,
    output logic [AW-1:0]         raddr,
    input  logic [7:0]            rdata
);
    import gbe_pkg::*;

    // Wide enough for pointer plus amount magnitude without overflow.
    localparam int XW = (AW > AMOUNT_W) ? AW + 1 : AMOUNT_W + 1;
    // Wide enough to hold a pointer or a ten-bit field before masking.
    localparam int OW = (AW > FIELD_W) ? AW : FIELD_W;
    localparam logic [AW-1:0] TOP = AW'(CAPACITY - 1);
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

    state_t state_reg, state_next;

    logic [AW-1:0] hs_reg, hs_next;
    logic [AW-1:0] he_reg, he_next;
    logic [AMOUNT_W:0] cnt_reg, cnt_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic          fwd_reg, fwd_next;
    logic          wr_pend_reg, wr_pend_next;
    logic          result_valid_reg, result_valid_next;

    status_t       pend_status_reg, pend_status_next;
    logic [7:0]    pend_byte_reg, pend_byte_next;
    status_t       status_reg, status_next;
    logic [7:0]    read_byte_reg, read_byte_next;
    logic [9:0]    cursor_reg, cursor_next;
    logic [9:0]    text_length_reg, text_length_next;

    // Decode of the offered item against the current gap.
    logic          accept;
    logic          neg;
    logic          forward;
    logic [AMOUNT_W:0] mag12;
    logic [XW-1:0] mag_x;
    logic [XW-1:0] hs_x;
    logic [XW-1:0] fwd_target;
    logic          fwd_bad;
    logic          bwd_bad;
    logic          gap_ok;
    logic [AW-1:0] tlen;
    logic          read_bad;
    logic [AW-1:0] read_addr;
    logic          move_go;
    logic          read_go;
    logic          load_result;

    assign accept  = item_valid && (state_reg == S_IDLE);
    assign neg     = amount[AMOUNT_W-1];
    assign forward = (amount != '0) && !neg;
    assign mag12   = neg ? ((AMOUNT_W+1)'(2 ** AMOUNT_W) - {1'b0, amount})
                         : {1'b0, amount};
    assign mag_x   = XW'(mag12);
    assign hs_x    = XW'(hs_reg);
    assign fwd_target = XW'(he_reg) + mag_x;
    assign fwd_bad = fwd_target >= CAP_X;
    assign bwd_bad = mag_x > hs_x;
    assign gap_ok  = he_reg > hs_reg;
    assign tlen    = TOP - (he_reg - hs_reg);
    assign read_bad = XW'(position) >= XW'(tlen);
    assign read_addr = (XW'(position) < hs_x)
                     ? AW'(XW'(position))
                     : AW'(XW'(position)) - hs_reg + he_reg + AW'(1);
    assign move_go = (opcode == OP_MOVE) && (mag12 != '0)
                   && (forward ? !fwd_bad : !bwd_bad);
    assign read_go = (opcode == OP_READ) && !read_bad;
    assign load_result = (state_reg == S_RESULT) && (!result_valid_reg || result_ready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (move_go)
                    begin
                        state_next = S_COPY;
                    end
                    else if (read_go)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_COPY:
            begin
                if (cnt_reg == (AMOUNT_W+1)'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:  state_next = S_RESULT;
            S_READ:   state_next = S_RESULT;
            S_RESULT:
            begin
                if (load_result)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath, memory control and result register.
    always_comb
    begin
        logic [OW-1:0] hs_w;
        logic [OW-1:0] tl_w;

        hs_next          = hs_reg;
        he_next          = he_reg;
        cnt_next         = cnt_reg;
        rd_ptr_next      = rd_ptr_reg;
        wr_ptr_next      = wr_ptr_reg;
        fwd_next         = fwd_reg;
        wr_pend_next     = (state_reg == S_COPY);
        pend_status_next = pend_status_reg;
        pend_byte_next   = pend_byte_reg;
        status_next      = status_reg;
        read_byte_next   = read_byte_reg;
        cursor_next      = cursor_reg;
        text_length_next = text_length_reg;
        result_valid_next = result_valid_reg;
        mem_ctl          = '0;
        waddr            = wr_ptr_reg;
        wdata            = rdata;
        raddr            = rd_ptr_reg;
        hs_w             = OW'(hs_reg);
        tl_w             = OW'(tlen);

        if (accept)
        begin
            pend_byte_next   = '0;
            pend_status_next = ST_OK;
            case (opcode)
                OP_INSERT:
                begin
                    if (gap_ok)
                    begin
                        mem_ctl.wr_en = 1'b1;
                        waddr         = hs_reg;
                        wdata         = insert_byte;
                        hs_next       = hs_reg + AW'(1);
                    end
                    else
                    begin
                        pend_status_next = ST_FULL;
                    end
                end
                OP_MOVE, OP_ERASE:
                begin
                    if (forward ? fwd_bad : bwd_bad)
                    begin
                        pend_status_next = ST_RANGE;
                    end
                    else if (forward)
                    begin
                        he_next = AW'(fwd_target);
                        if (opcode == OP_MOVE)
                        begin
                            hs_next     = AW'(hs_x + mag_x);
                            rd_ptr_next = he_reg + AW'(1);
                            wr_ptr_next = hs_reg;
                        end
                    end
                    else
                    begin
                        hs_next = AW'(hs_x - mag_x);
                        if (opcode == OP_MOVE)
                        begin
                            he_next     = AW'(XW'(he_reg) - mag_x);
                            rd_ptr_next = hs_reg - AW'(1);
                            wr_ptr_next = he_reg;
                        end
                    end
                    fwd_next = forward;
                    cnt_next = mag12;
                end
                OP_READ:
                begin
                    if (read_bad)
                    begin
                        pend_status_next = ST_RANGE;
                    end
                    else
                    begin
                        mem_ctl.rd_en = 1'b1;
                        raddr         = read_addr;
                    end
                end
                OP_CLEAR:
                begin
                    hs_next = '0;
                    he_next = TOP;
                end
                default:
                begin
                    pend_status_next = ST_RANGE;
                end
            endcase
        end

        // Copy loop: one read issued per cycle, its byte written back the
        // cycle after. Read and write addresses stay on opposite sides of
        // the gap, so they never meet.
        if (state_reg == S_COPY)
        begin
            mem_ctl.rd_en = 1'b1;
            raddr         = rd_ptr_reg;
            rd_ptr_next   = fwd_reg ? rd_ptr_reg + AW'(1) : rd_ptr_reg - AW'(1);
            cnt_next      = cnt_reg - (AMOUNT_W+1)'(1);
        end
        if (wr_pend_reg)
        begin
            mem_ctl.wr_en = 1'b1;
            waddr         = wr_ptr_reg;
            wdata         = rdata;
            wr_ptr_next   = fwd_reg ? wr_ptr_reg + AW'(1) : wr_ptr_reg - AW'(1);
        end

        if (state_reg == S_READ)
        begin
            pend_byte_next = rdata;
        end

        if (load_result)
        begin
            status_next       = pend_status_reg;
            read_byte_next    = pend_byte_reg;
            cursor_next       = hs_w[FIELD_W-1:0];
            text_length_next  = tl_w[FIELD_W-1:0];
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            hs_reg           <= '0;
            he_reg           <= TOP;
            wr_pend_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            hs_reg           <= hs_next;
            he_reg           <= he_next;
            wr_pend_reg      <= wr_pend_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg         <= cnt_next;
        rd_ptr_reg      <= rd_ptr_next;
        wr_ptr_reg      <= wr_ptr_next;
        fwd_reg         <= fwd_next;
        pend_status_reg <= pend_status_next;
        pend_byte_reg   <= pend_byte_next;
        status_reg      <= status_next;
        read_byte_reg   <= read_byte_next;
        cursor_reg      <= cursor_next;
        text_length_reg <= text_length_next;
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign read_byte    = read_byte_reg;
    assign cursor       = cursor_reg;
    assign text_length  = text_length_reg;

endmodule

/* rtl/core/gap_buffer_editor.sv */
// Gap buffer editor holding up to CAPACITY-1 bytes of text with the cursor at
// the gap. One transaction on the item channel carries one operation and
// yields one result transaction. Insert, erase, clear, a zero move, failed
// operations and unknown opcodes go from acceptance straight to the result
// state, where the result is registered. A read passes a read state first
// because of the registered read port of the text store; a move of n bytes
// first passes the copy loop, which carries the bytes across the gap one by
// one through the store's single read and write ports, then a drain state.
// The next item is accepted in the cycle after the result is registered,
// even while that result still waits on result_ready; the following result
// then waits until the earlier one is taken. The text store has no reset.
module gap_buffer_editor #(
    parameter int CAPACITY = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [2:0]         opcode,
    input  logic [7:0]         insert_byte,
    input  logic signed [10:0] amount,
    input  logic [9:0]         position,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [1:0]         status,
    output logic [7:0]         read_byte,
    output logic [9:0]         cursor,
    output logic [9:0]         text_length
);
    import gbe_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    mem_ctl_t      mem_ctl;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;

    gbe_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .opcode       (opcode),
        .insert_byte  (insert_byte),
        .amount       (amount),
        .position     (position),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .read_byte    (read_byte),
        .cursor       (cursor),
        .text_length  (text_length),
        .mem_ctl      (mem_ctl),
        .waddr        (waddr),
        .wdata        (wdata),
        .raddr        (raddr),
        .rdata        (rdata)
    );

    gbe_text_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_text_ram (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr   (raddr),
        .rdata   (rdata)
    );

endmodule

/* tb/gap_edit_tracker_pkg.sv */
// Result tracking for the gap buffer editor testbench: a software copy of the
// text store and gap bounds that predicts each result, plus the result check.
// Depends on gbe_pkg for the opcode and status codes.
`timescale 1ns / 1ps
package gap_edit_tracker_pkg;

    import gbe_pkg::*;

    localparam int TEXT_SLOTS = 1024;

    typedef struct packed {
        status_t              status;
        logic [7:0]           read_byte;
        logic [FIELD_W-1:0]   cursor;
        logic [FIELD_W-1:0]   text_length;
    } edit_result_t;

    class edit_tracker;
        logic [7:0]   text_mem [TEXT_SLOTS];
        int unsigned  hole_start;
        int unsigned  hole_end;
        edit_result_t pending_results [$];
        int           items_noted;
        int           mismatches;

        function new();
            hole_start  = 0;
            hole_end    = TEXT_SLOTS - 1;
            items_noted = 0;
            mismatches  = 0;
            foreach (text_mem[i])
            begin
                text_mem[i] = 8'h00;
            end
        endfunction

        function int unsigned gap_slots();
            return hole_end - hole_start + 1;
        endfunction

        function int unsigned text_len();
            return TEXT_SLOTS - gap_slots();
        endfunction

        function int unsigned after_len();
            return TEXT_SLOTS - 1 - hole_end;
        endfunction

        // Applies one accepted operation to the tracked text and queues the
        // result it must produce.
        function void note_item(logic [2:0] op, logic [7:0] data,
                                logic signed [10:0] amt, logic [9:0] pos);
            int           step;
            int unsigned  mag;
            int unsigned  goal;
            bit           forward;
            edit_result_t res;
            step      = amt;
            forward   = step > 0;
            mag       = (step < 0) ? -step : step;
            res.status    = ST_OK;
            res.read_byte = 8'h00;
            case (op)
                OP_INSERT:
                begin
                    if (gap_slots() >= 2)
                    begin
                        text_mem[hole_start] = data;
                        hole_start++;
                    end
                    else
                        res.status = ST_FULL;
                end
                OP_MOVE, OP_ERASE:
                begin
                    if (forward)
                    begin
                        goal = hole_end + mag;
                        if (goal >= TEXT_SLOTS)
                            res.status = ST_RANGE;
                        else if (op == OP_ERASE)
                            hole_end = goal;
                        else
                        begin
                            while (hole_end != goal)
                            begin
                                hole_end++;
                                text_mem[hole_start] = text_mem[hole_end];
                                hole_start++;
                            end
                        end
                    end
                    else
                    begin
                        if (mag > hole_start)
                            res.status = ST_RANGE;
                        else if (op == OP_ERASE)
                            hole_start = hole_start - mag;
                        else
                        begin
                            goal = hole_start - mag;
                            while (hole_start != goal)
                            begin
                                hole_start--;
                                text_mem[hole_end] = text_mem[hole_start];
                                hole_end--;
                            end
                        end
                    end
                end
                OP_READ:
                begin
                    if (pos >= text_len())
                        res.status = ST_RANGE;
                    else if (pos < hole_start)
                        res.read_byte = text_mem[pos];
                    else
                        res.read_byte = text_mem[hole_end + 1 + (pos - hole_start)];
                end
                OP_CLEAR:
                begin
                    hole_start = 0;
                    hole_end   = TEXT_SLOTS - 1;
                end
                default:
                    res.status = ST_RANGE;
            endcase
            res.cursor      = FIELD_W'(hole_start);
            res.text_length = FIELD_W'(text_len());
            pending_results.push_back(res);
            items_noted++;
        endfunction

        function void check_result(logic [1:0] status, logic [7:0] read_byte,
                                   logic [9:0] cursor, logic [9:0] text_length);
            edit_result_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: result with none outstanding: status %0d byte %02h cursor %0d length %0d",
                             $realtime, status, read_byte, cursor, text_length);
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status || read_byte !== want.read_byte ||
                cursor !== want.cursor || text_length !== want.text_length)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: result differs: expected status %0d byte %02h cursor %0d length %0d, got status %0d byte %02h cursor %0d length %0d",
                             $realtime, want.status, want.read_byte, want.cursor,
                             want.text_length, status, read_byte, cursor, text_length);
            end
        endfunction

        // Anything still queued at the end never came out of the block.
        function void close_out();
            if (pending_results.size() != 0)
            begin
                mismatches += pending_results.size();
                $display("%0d results never arrived", pending_results.size());
            end
        endfunction
    endclass

endpackage

/* tb/testbench.sv */
// Top-level testbench for gap_buffer_editor: drives edit operations with
// random idle gaps and back-pressure, and checks every result transaction.
// Depends on gbe_pkg and gap_edit_tracker_pkg.
`timescale 1ns / 1ps
module testbench;

    import gbe_pkg::*;
    import gap_edit_tracker_pkg::*;

    localparam int IDLE_LIMIT      = 5000;
    localparam int RANDOM_ITEMS    = 700;
    localparam int HOLD_OFF_AFTER  = 120;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int DRAIN_CYCLES    = 40;
    localparam logic [2:0] OP_BAD_FIRST = 3'd5;
    localparam logic [2:0] OP_BAD_LAST  = 3'd7;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_ready;
    logic [2:0]         opcode       = OP_INSERT;
    logic [7:0]         insert_byte  = 8'h00;
    logic signed [10:0] amount       = '0;
    logic [9:0]         position     = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic [1:0]         status;
    logic [7:0]         read_byte;
    logic [9:0]         cursor;
    logic [9:0]         text_length;

    bit steady = 1'b0;

    edit_tracker tracker = new();

    gap_buffer_editor #(
        .CAPACITY(TEXT_SLOTS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .opcode       (opcode),
        .insert_byte  (insert_byte),
        .amount       (amount),
        .position     (position),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .read_byte    (read_byte),
        .cursor       (cursor),
        .text_length  (text_length)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(30, 4);
    endfunction

    // Offers one operation, holds it until the block takes it, then records it.
    task send_item(input logic [2:0] op, input logic [7:0] data, input int amt,
                   input int pos);
        int gap;
        item_valid  <= 1'b1;
        opcode      <= op;
        insert_byte <= data;
        amount      <= 11'(amt);
        position    <= 10'(pos);
        do
            @(posedge clk);
        while (!item_ready);
        tracker.note_item(op, data, 11'(amt), 10'(pos));
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Legal shift for a move or erase, bounded by the text on that side.
    function int legal_amount(int cap);
        int room;
        if ($urandom_range(1))
        begin
            room = tracker.after_len();
            if (room > cap)
                room = cap;
            return $urandom_range(room);
        end
        room = tracker.hole_start;
        if (room > cap)
            room = cap;
        return -int'($urandom_range(room));
    endfunction

    task random_edit(input bit long_moves);
        int          r;
        int          amt;
        int          pos;
        int          len;
        logic [2:0]  op;
        r   = $urandom_range(99);
        len = tracker.text_len();
        amt = int'($urandom_range(2046)) - 1023;
        pos = $urandom_range(1023);
        if (r < 34)
            op = OP_INSERT;
        else if (r < 54)
            op = OP_MOVE;
        else if (r < 64)
            op = OP_ERASE;
        else if (r < 94)
            op = OP_READ;
        else if (r < 97)
            op = OP_CLEAR;
        else
            op = 3'($urandom_range(OP_BAD_LAST, OP_BAD_FIRST));
        if (op == OP_MOVE && $urandom_range(9) < 8)
            amt = legal_amount(long_moves ? 1023 : 48);
        else if (op == OP_ERASE && $urandom_range(9) < 8)
            amt = legal_amount(12);
        if (op == OP_READ)
        begin
            r = $urandom_range(9);
            if (len > 0 && r < 7)
                pos = $urandom_range(len - 1);
            else if (r < 8)
                pos = len;
        end
        send_item(op, 8'($urandom_range(255)), amt, pos);
    endtask

    initial
    begin
        int sent;
        int run_len;
        do
            @(posedge clk);
        while (!rst_n);

        // Empty buffer: reads, zero and unit moves, unknown opcodes.
        send_item(OP_READ, 8'h00, 0, 0);
        send_item(OP_READ, 8'h00, 0, 1023);
        send_item(OP_MOVE, 8'h00, 0, 0);
        send_item(OP_MOVE, 8'h00, 1, 0);
        send_item(OP_MOVE, 8'h00, -1, 0);
        send_item(OP_BAD_FIRST, 8'h00, 0, 0);
        send_item(OP_BAD_LAST, 8'h00, 0, 0);
        // Short text, cursor moves both ways, erases on both sides, out-of-range shifts, clear.
        send_item(OP_INSERT, 8'h00, 0, 0);
        send_item(OP_INSERT, 8'hFF, 0, 0);
        send_item(OP_INSERT, 8'hA5, 0, 0);
        send_item(OP_INSERT, 8'h5A, 0, 0);
        send_item(OP_READ, 8'h00, 0, 0);
        send_item(OP_READ, 8'h00, 0, 3);
        send_item(OP_READ, 8'h00, 0, 4);
        send_item(OP_MOVE, 8'h00, -4, 0);
        send_item(OP_MOVE, 8'h00, 4, 0);
        send_item(OP_MOVE, 8'h00, -2, 0);
        send_item(OP_ERASE, 8'h00, 1, 0);
        send_item(OP_ERASE, 8'h00, -1, 0);
        send_item(OP_MOVE, 8'h00, 1023, 0);
        send_item(OP_MOVE, 8'h00, -1023, 0);
        send_item(OP_ERASE, 8'h00, 1023, 0);
        send_item(OP_ERASE, 8'h00, -1023, 0);
        send_item(OP_READ, 8'h00, 0, 1);
        send_item(OP_CLEAR, 8'h00, 0, 0);
        send_item(OP_READ, 8'h00, 0, 0);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            steady  = ($urandom_range(3) == 0);
            run_len = $urandom_range(40, 10);
            repeat (run_len)
            begin
                random_edit($urandom_range(19) == 0);
                sent++;
            end
        end
        item_valid <= 1'b0;

        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        tracker.close_out();
        if (tracker.mismatches == 0)
            $display("gap_buffer_editor: match");
        else
            $display("gap_buffer_editor: mismatch");
        $finish;
    end

    // Result side back-pressure, including one long hold-off that backs up the
    // block while the item side keeps offering.
    initial
    begin
        bit held;
        int r;
        int hold_len;
        held = 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (!held && tracker.items_noted >= HOLD_OFF_AFTER)
            begin
                held = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            r = $urandom_range(99);
            if (r < 60)
            begin
                result_ready <= 1'b1;
                hold_len = $urandom_range(20, 1);
            end
            else if (r < 90)
            begin
                result_ready <= 1'b0;
                hold_len = $urandom_range(3, 1);
            end
            else
            begin
                result_ready <= 1'b0;
                hold_len = $urandom_range(30, 4);
            end
            repeat (hold_len) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            tracker.check_result(status, read_byte, cursor, text_length);
    end

    // Ends the run if no transaction on either channel completes for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("gap_buffer_editor: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/gbe_pkg.sv
rtl/core/gbe_text_ram.sv
rtl/core/gbe_ctrl.sv
rtl/core/gap_buffer_editor.sv
tb/gap_edit_tracker_pkg.sv
tb/testbench.sv
